FILE: sv/bfd_pkg.sv
// shared constants, types and codes for the box filter downscaler
package bfd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 8;
    localparam int EXT_W     = 16;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int XS_W  = COL_W + 1;
    localparam int YS_W  = ROW_W + 1;

    localparam int SUM_W  = 2 * PIX_W + COL_W + ROW_W;
    localparam int ASUM_W = PIX_W + COL_W + ROW_W;
    localparam int CNT_W  = COL_W + ROW_W + 1;

    localparam int DVD_W     = SUM_W + 1;
    localparam int DVS_W     = ASUM_W;
    localparam int DIV_LANES = 4;
    localparam int DCNT_W    = $clog2(DVD_W + 1);

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_ALPHA = 3;
    localparam int LANE_COLS  = 0;
    localparam int LANE_ROWS  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    typedef logic [DVD_W-1:0] dvd_t;
    typedef logic [DVS_W-1:0] dvs_t;

    typedef struct packed {
        logic [SUM_W-1:0]  red;
        logic [SUM_W-1:0]  green;
        logic [SUM_W-1:0]  blue;
        logic [ASUM_W-1:0] asum;
        logic [CNT_W-1:0]  cnt;
    } acc_t;

    typedef struct packed {
        logic [XS_W-1:0] sw;
        logic [XS_W-1:0] dw;
        logic [YS_W-1:0] sh;
        logic [YS_W-1:0] dh;
    } dims_t;

    typedef struct packed {
        logic [COL_W-1:0] dest_x;
        logic [ROW_W-1:0] dest_y;
        logic             last_col;
        logic             last_row;
        logic             frame_end;
    } pos_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE
    } state_t;

endpackage

FILE: sv/bfd_acc_mem.sv
// per-column accumulator memory, registered read
module bfd_acc_mem (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [bfd_pkg::COL_W-1:0] rd_addr,
    output bfd_pkg::acc_t             rd_data,
    input  logic                      wr_en,
    input  logic [bfd_pkg::COL_W-1:0] wr_addr,
    input  bfd_pkg::acc_t             wr_data
);
    import bfd_pkg::*;

    acc_t mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/bfd_div.sv
// multi-lane restoring divider, one quotient bit per cycle
module bfd_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  bfd_pkg::dvd_t dvd [bfd_pkg::DIV_LANES],
    input  bfd_pkg::dvs_t dvs [bfd_pkg::DIV_LANES],
    output logic          busy,
    output bfd_pkg::dvd_t quo [bfd_pkg::DIV_LANES],
    output bfd_pkg::dvs_t rem [bfd_pkg::DIV_LANES]
);
    import bfd_pkg::*;

    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    dvd_t              quo_reg  [DIV_LANES];
    dvd_t              quo_next [DIV_LANES];
    dvs_t              rem_reg  [DIV_LANES];
    dvs_t              rem_next [DIV_LANES];
    dvs_t              dvs_reg  [DIV_LANES];
    logic [DVS_W:0]    trial    [DIV_LANES];

    assign busy = (cnt_reg != '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < DIV_LANES; i++)
        begin
            trial[i]    = {rem_reg[i], quo_reg[i][DVD_W-1]} - {1'b0, dvs_reg[i]};
            quo_next[i] = quo_reg[i];
            rem_next[i] = rem_reg[i];
        end
        if (start)
        begin
            cnt_next = DCNT_W'(DVD_W);
            for (int i = 0; i < DIV_LANES; i++)
            begin
                quo_next[i] = dvd[i];
                rem_next[i] = '0;
            end
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            for (int i = 0; i < DIV_LANES; i++)
            begin
                if (!trial[i][DVS_W])
                begin
                    rem_next[i] = trial[i][DVS_W-1:0];
                    quo_next[i] = {quo_reg[i][DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = {rem_reg[i][DVS_W-2:0], quo_reg[i][DVD_W-1]};
                    quo_next[i] = {quo_reg[i][DVD_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_LANES; i++)
        begin
            quo_reg[i] <= quo_next[i];
            rem_reg[i] <= rem_next[i];
            if (start)
            begin
                dvs_reg[i] <= dvs[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DIV_LANES; i++)
        begin
            quo[i] = quo_reg[i];
            rem[i] = rem_reg[i];
        end
    end

endmodule

FILE: sv/bfd_pos.sv
// source and destination position tracking with incremental footprint bounds
module bfd_pos (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     restart,
    input  logic                     step,
    input  bfd_pkg::dims_t           dims,
    input  logic [bfd_pkg::XS_W-1:0] col_q0,
    input  logic [bfd_pkg::XS_W-1:0] col_r0,
    input  logic [bfd_pkg::YS_W-1:0] row_q0,
    input  logic [bfd_pkg::YS_W-1:0] row_r0,
    output bfd_pkg::pos_t            pos
);
    import bfd_pkg::*;

    logic [COL_W-1:0] src_col_reg, src_col_next;
    logic [COL_W-1:0] dst_col_reg, dst_col_next;
    logic [XS_W-1:0]  col_bnd_reg, col_bnd_next;
    logic [XS_W-1:0]  col_rem_reg, col_rem_next;
    logic [XS_W-1:0]  col_q0_reg, col_q0_next;
    logic [XS_W-1:0]  col_r0_reg, col_r0_next;
    logic [ROW_W-1:0] src_row_reg, src_row_next;
    logic [ROW_W-1:0] dst_row_reg, dst_row_next;
    logic [YS_W-1:0]  row_bnd_reg, row_bnd_next;
    logic [YS_W-1:0]  row_rem_reg, row_rem_next;
    logic [YS_W-1:0]  row_q0_reg, row_q0_next;
    logic [YS_W-1:0]  row_r0_reg, row_r0_next;

    logic [XS_W-1:0] src_col_inc, dst_col_inc;
    logic [YS_W-1:0] src_row_inc, dst_row_inc;
    logic [XS_W:0]   col_rsum;
    logic [YS_W:0]   row_rsum;
    logic            col_wrap, row_wrap;
    logic            last_col, last_row;

    assign src_col_inc = {1'b0, src_col_reg} + 1'b1;
    assign dst_col_inc = {1'b0, dst_col_reg} + 1'b1;
    assign src_row_inc = {1'b0, src_row_reg} + 1'b1;
    assign dst_row_inc = {1'b0, dst_row_reg} + 1'b1;
    assign last_col    = (src_col_inc >= col_bnd_reg);
    assign last_row    = (src_row_inc >= row_bnd_reg);
    assign col_rsum    = {1'b0, col_rem_reg} + {1'b0, col_r0_reg};
    assign row_rsum    = {1'b0, row_rem_reg} + {1'b0, row_r0_reg};
    assign col_wrap    = (col_rsum >= {1'b0, dims.dw});
    assign row_wrap    = (row_rsum >= {1'b0, dims.dh});

    assign pos.dest_x    = dst_col_reg;
    assign pos.dest_y    = dst_row_reg;
    assign pos.last_col  = last_col;
    assign pos.last_row  = last_row;
    assign pos.frame_end = (dst_col_inc >= dims.dw) && (dst_row_inc >= dims.dh);

    always_comb
    begin
        src_col_next = src_col_reg;
        dst_col_next = dst_col_reg;
        col_bnd_next = col_bnd_reg;
        col_rem_next = col_rem_reg;
        col_q0_next  = col_q0_reg;
        col_r0_next  = col_r0_reg;
        src_row_next = src_row_reg;
        dst_row_next = dst_row_reg;
        row_bnd_next = row_bnd_reg;
        row_rem_next = row_rem_reg;
        row_q0_next  = row_q0_reg;
        row_r0_next  = row_r0_reg;
        if (restart)
        begin
            src_col_next = '0;
            dst_col_next = '0;
            col_bnd_next = col_q0;
            col_rem_next = col_r0;
            col_q0_next  = col_q0;
            col_r0_next  = col_r0;
            src_row_next = '0;
            dst_row_next = '0;
            row_bnd_next = row_q0;
            row_rem_next = row_r0;
            row_q0_next  = row_q0;
            row_r0_next  = row_r0;
        end
        else if (step)
        begin
            if (!last_col)
            begin
                src_col_next = src_col_inc[COL_W-1:0];
            end
            else if ((src_col_inc < dims.sw) && (dst_col_inc < dims.dw))
            begin
                src_col_next = src_col_inc[COL_W-1:0];
                dst_col_next = dst_col_inc[COL_W-1:0];
                col_bnd_next = col_bnd_reg + col_q0_reg + XS_W'(col_wrap);
                col_rem_next = col_wrap ? XS_W'(col_rsum - {1'b0, dims.dw})
                                        : col_rsum[XS_W-1:0];
            end
            else
            begin
                src_col_next = '0;
                dst_col_next = '0;
                col_bnd_next = col_q0_reg;
                col_rem_next = col_r0_reg;
                if (!last_row)
                begin
                    src_row_next = src_row_inc[ROW_W-1:0];
                end
                else if ((src_row_inc < dims.sh) && (dst_row_inc < dims.dh))
                begin
                    src_row_next = src_row_inc[ROW_W-1:0];
                    dst_row_next = dst_row_inc[ROW_W-1:0];
                    row_bnd_next = row_bnd_reg + row_q0_reg + YS_W'(row_wrap);
                    row_rem_next = row_wrap ? YS_W'(row_rsum - {1'b0, dims.dh})
                                            : row_rsum[YS_W-1:0];
                end
                else
                begin
                    src_row_next = '0;
                    dst_row_next = '0;
                    row_bnd_next = row_q0_reg;
                    row_rem_next = row_r0_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            dst_col_reg <= '0;
            col_bnd_reg <= XS_W'(1);
            col_rem_reg <= '0;
            col_q0_reg  <= XS_W'(1);
            col_r0_reg  <= '0;
            src_row_reg <= '0;
            dst_row_reg <= '0;
            row_bnd_reg <= YS_W'(1);
            row_rem_reg <= '0;
            row_q0_reg  <= YS_W'(1);
            row_r0_reg  <= '0;
        end
        else
        begin
            src_col_reg <= src_col_next;
            dst_col_reg <= dst_col_next;
            col_bnd_reg <= col_bnd_next;
            col_rem_reg <= col_rem_next;
            col_q0_reg  <= col_q0_next;
            col_r0_reg  <= col_r0_next;
            src_row_reg <= src_row_next;
            dst_row_reg <= dst_row_next;
            row_bnd_reg <= row_bnd_next;
            row_rem_reg <= row_rem_next;
            row_q0_reg  <= row_q0_next;
            row_r0_reg  <= row_r0_next;
        end
    end

endmodule

FILE: sv/box_filter_image_downscale_top.sv
// top level of the premultiplied alpha box filter downscaler
//
//  channel  dir  handshake            payload
//  s_axis   in   s_tvalid/s_tready    s_tdata: red, green, blue, alpha
//  m_axis   out  m_tvalid/m_tready    m_tdata: red, green, blue, alpha, x, y; m_tlast
//  cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  a pixel that closes no footprint passes through accept, then the
//  read-modify-write of its column entry in the accumulator memory
//  a pixel that closes a footprint adds the shared divider, then the output load
//  reset and every configuration write start a clearing pass over all 1024
//  columns of the accumulator memory, one column a cycle, with s_tready low
//  a finished pixel waits in the output register while the next beat is taken
module box_filter_image_downscale_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // in_red, in_green, in_blue, in_alpha
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [55:0]                   m_tdata,   // out_red, out_green, out_blue,
                                                     // out_alpha, dest_x, dest_y
    output logic                          m_tlast,   // frame_end
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfd_pkg::CFG_W-1:0]     cfg_data
);
    import bfd_pkg::*;

    function automatic logic [EXT_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                     input logic [EXT_W-1:0] hi);
        logic [EXT_W-1:0] ve;
        ve = EXT_W'(v);
        if (ve == '0)
        begin
            return EXT_W'(1);
        end
        return (ve > hi) ? hi : ve;
    endfunction

    function automatic logic [PIX_W-1:0] sat_pixel(input dvd_t q);
        return (q > DVD_W'(255)) ? PIX_W'(255) : q[PIX_W-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [EXT_W-1:0] eff_sw, eff_sh, eff_dw, eff_dh;
    dims_t            dims;

    logic [XS_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic            setup_reg;

    logic [PIX_W-1:0] pix_red_reg, pix_green_reg, pix_blue_reg, pix_alpha_reg;

    logic [COL_W-1:0] pend_x_reg;
    logic [ROW_W-1:0] pend_y_reg;
    logic             pend_last_reg;
    logic             pend_azero_reg;

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;
    logic [COL_W-1:0] out_x_reg;
    logic [ROW_W-1:0] out_y_reg;
    logic             out_last_reg;

    logic cfg_wr, accept, emit, mem_rd_en, mem_wr_en, pos_step, pos_restart;
    logic div_start, div_busy, out_load, emit_latch;
    logic [COL_W-1:0] mem_wr_addr;
    acc_t             mem_rd_data, mem_wr_data, acc_new;
    pos_t             pos;

    logic [2*PIX_W-1:0] prod_red, prod_green, prod_blue;

    dvd_t div_dvd [DIV_LANES];
    dvs_t div_dvs [DIV_LANES];
    dvd_t div_quo [DIV_LANES];
    dvs_t div_rem [DIV_LANES];

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign accept    = s_tvalid & s_tready;
    assign emit      = pos.last_col & pos.last_row;

    assign eff_sw = clamp_size(src_w_reg, EXT_W'(MAX_WIDTH));
    assign eff_sh = clamp_size(src_h_reg, EXT_W'(MAX_HEIGHT));
    assign eff_dw = clamp_size(dst_w_reg, eff_sw);
    assign eff_dh = clamp_size(dst_h_reg, eff_sh);
    assign dims.sw = eff_sw[XS_W-1:0];
    assign dims.dw = eff_dw[XS_W-1:0];
    assign dims.sh = eff_sh[YS_W-1:0];
    assign dims.dh = eff_dh[YS_W-1:0];

    assign prod_red   = pix_red_reg * pix_alpha_reg;
    assign prod_green = pix_green_reg * pix_alpha_reg;
    assign prod_blue  = pix_blue_reg * pix_alpha_reg;

    always_comb
    begin
        acc_new.red   = mem_rd_data.red + SUM_W'(prod_red);
        acc_new.green = mem_rd_data.green + SUM_W'(prod_green);
        acc_new.blue  = mem_rd_data.blue + SUM_W'(prod_blue);
        acc_new.asum  = mem_rd_data.asum + ASUM_W'(pix_alpha_reg);
        acc_new.cnt   = mem_rd_data.cnt + 1'b1;
    end

    always_comb
    begin
        for (int i = 0; i < DIV_LANES; i++)
        begin
            div_dvd[i] = '0;
            div_dvs[i] = '0;
        end
        if (setup_reg)
        begin
            div_dvd[LANE_COLS] = DVD_W'(dims.sw);
            div_dvs[LANE_COLS] = DVS_W'(dims.dw);
            div_dvd[LANE_ROWS] = DVD_W'(dims.sh);
            div_dvs[LANE_ROWS] = DVS_W'(dims.dh);
        end
        else
        begin
            div_dvd[LANE_RED]   = DVD_W'(acc_new.red) + DVD_W'(acc_new.asum >> 1);
            div_dvd[LANE_GREEN] = DVD_W'(acc_new.green) + DVD_W'(acc_new.asum >> 1);
            div_dvd[LANE_BLUE]  = DVD_W'(acc_new.blue) + DVD_W'(acc_new.asum >> 1);
            div_dvd[LANE_ALPHA] = DVD_W'(acc_new.asum);
            div_dvs[LANE_RED]   = acc_new.asum;
            div_dvs[LANE_GREEN] = acc_new.asum;
            div_dvs[LANE_BLUE]  = acc_new.asum;
            div_dvs[LANE_ALPHA] = DVS_W'(acc_new.cnt);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        s_tready       = 1'b0;
        mem_rd_en      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = pos.dest_x;
        mem_wr_data    = acc_new;
        pos_step       = 1'b0;
        pos_restart    = 1'b0;
        div_start      = setup_reg;
        emit_latch     = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg & ~m_tready;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg != XS_W'(MAX_WIDTH))
                begin
                    mem_wr_en    = 1'b1;
                    mem_wr_addr  = clr_cnt_reg[COL_W-1:0];
                    mem_wr_data  = '0;
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
                else if (!div_busy && !setup_reg)
                begin
                    pos_restart = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                mem_rd_en = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                mem_wr_en = 1'b1;
                pos_step  = 1'b1;
                if (emit)
                begin
                    mem_wr_data = '0;
                    div_start   = 1'b1;
                    emit_latch  = 1'b1;
                    state_next  = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (!div_busy && (!out_valid_reg || m_tready))
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_wr)
        begin
            state_next   = ST_CLEAR;
            clr_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            setup_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            src_w_reg     <= CFG_W'(1);
            src_h_reg     <= CFG_W'(1);
            dst_w_reg     <= CFG_W'(1);
            dst_h_reg     <= CFG_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            setup_reg     <= cfg_wr;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_SRC_WIDTH:  src_w_reg <= cfg_data;
                    REG_SRC_HEIGHT: src_h_reg <= cfg_data;
                    REG_DST_WIDTH:  dst_w_reg <= cfg_data;
                    REG_DST_HEIGHT: dst_h_reg <= cfg_data;
                    default:        src_w_reg <= src_w_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_red_reg   <= s_tdata[7:0];
            pix_green_reg <= s_tdata[15:8];
            pix_blue_reg  <= s_tdata[23:16];
            pix_alpha_reg <= s_tdata[31:24];
        end
        if (emit_latch)
        begin
            pend_x_reg     <= pos.dest_x;
            pend_y_reg     <= pos.dest_y;
            pend_last_reg  <= pos.frame_end;
            pend_azero_reg <= (acc_new.asum == '0);
        end
        if (out_load)
        begin
            out_red_reg   <= pend_azero_reg ? '0 : sat_pixel(div_quo[LANE_RED]);
            out_green_reg <= pend_azero_reg ? '0 : sat_pixel(div_quo[LANE_GREEN]);
            out_blue_reg  <= pend_azero_reg ? '0 : sat_pixel(div_quo[LANE_BLUE]);
            out_alpha_reg <= sat_pixel(div_quo[LANE_ALPHA]);
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_last_reg  <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = 56'({out_y_reg, out_x_reg, out_alpha_reg,
                           out_blue_reg, out_green_reg, out_red_reg});

    bfd_acc_mem u_acc_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (pos.dest_x),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    bfd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .dvd   (div_dvd),
        .dvs   (div_dvs),
        .busy  (div_busy),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    bfd_pos u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (pos_restart),
        .step    (pos_step),
        .dims    (dims),
        .col_q0  (div_quo[LANE_COLS][XS_W-1:0]),
        .col_r0  (div_rem[LANE_COLS][XS_W-1:0]),
        .row_q0  (div_quo[LANE_ROWS][YS_W-1:0]),
        .row_r0  (div_rem[LANE_ROWS][YS_W-1:0]),
        .pos     (pos)
    );

endmodule
